>>> design/gawn_pkg.sv
`default_nettype none

package gawn_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 42;
    localparam int GSIZE_W    = 9;
    localparam int METHOD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    // Result reported for a group without any valid sample (-9999.0 in Q16.16).
    localparam logic signed [ACC_W-1:0] EMPTY_CODE = -42'sd655294464;

    // Register reset values.
    localparam logic [GSIZE_W-1:0] GSIZE_RST = 9'd12;

    // Reduction methods.
    typedef enum logic [METHOD_W-1:0] {
        METH_MEAN = 2'd0,
        METH_SUM  = 2'd1,
        METH_MAX  = 2'd2,
        METH_MIN  = 2'd3
    } t_method;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUP_SIZE    = 2'd0,
        CFG_METHOD        = 2'd1,
        CFG_NODATA_ENABLE = 2'd2,
        CFG_NODATA_VALUE  = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> design/gawn_div.sv
`default_nettype none

// Iterative signed divider: dividend by a positive count, one quotient bit
// per cycle with a single shared subtractor. The result truncates toward zero.
module gawn_div
    import gawn_pkg::*;
#(
    parameter int CNT_W = 9
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [ACC_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0]        i_divisor,
    output logic                         o_done,
    output logic signed [ACC_W-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_div;
    logic [ACC_W-1:0]   r_quo;
    logic               r_neg;

    logic [CNT_W:0]     w_trial;
    logic [CNT_W:0]     w_diff;
    logic               w_fit;
    logic [CNT_W-1:0]   n_rem;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        w_trial = {r_rem, r_quo[ACC_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[ACC_W-1];
            r_quo <= i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[ACC_W-2:0], w_fit};
        end
    end

    // The quotient takes the dividend's sign.
    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

>>> design/group_aggregate_with_nodata_core.sv
// An item is captured in IDLE and accumulated in ACC; no new item is taken until the
// block is back in IDLE. A closing item goes to OUT, which loads the output register
// once the previous result has been taken; for the mean it first waits in DIV for the
// bit-serial divider (42 steps), which sets the pace at group ends. Reset (synchronous,
// active low) clears the group state and output.
`default_nettype none

module group_aggregate_with_nodata_core
    import gawn_pkg::*;
#(
    parameter int MAX_GROUP = 365
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream: tdata = sample[31:0].
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Output stream: tdata = aggregate[41:0], zero padding[47:42].
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tuser = empty_res[0].
    output logic                        o_m_axis_tuser,
    // Configuration writes.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam logic [CNT_W-1:0] GROUP_MAX = CNT_W'(MAX_GROUP);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                     r_state;

    // Configuration registers.
    logic [GSIZE_W-1:0]         r_group_size;
    t_method                    r_method;
    logic                       r_nodata_en;
    logic signed [SAMPLE_W-1:0] r_nodata_val;

    // Group state.
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [ACC_W-1:0]    r_acc;
    logic [CNT_W-1:0]           r_vcnt;
    logic [CNT_W-1:0]           r_pos;
    logic                       r_have;
    logic signed [ACC_W-1:0]    r_res;
    logic                       r_res_empty;

    // Output register.
    logic                       r_out_valid;
    logic signed [ACC_W-1:0]    r_out_agg;
    logic                       r_out_empty;

    logic [CNT_W-1:0]           w_size;
    logic                       w_skip;
    logic signed [ACC_W-1:0]    w_sext;
    logic signed [ACC_W:0]      w_sum;
    logic signed [ACC_W-1:0]    w_sat;
    logic signed [ACC_W-1:0]    n_acc;
    logic [CNT_W-1:0]           n_vcnt;
    logic [CNT_W-1:0]           n_pos;
    logic                       w_close;
    logic                       w_div_start;
    logic                       w_div_done;
    logic signed [ACC_W-1:0]    w_quot;

    // Clamp the group size to the supported range.
    always_comb begin
        if (r_group_size < GSIZE_W'(2)) begin
            w_size = CNT_W'(2);
        end else if (32'(r_group_size) > 32'(MAX_GROUP)) begin
            w_size = GROUP_MAX;
        end else begin
            w_size = CNT_W'(r_group_size);
        end
    end

    // Accumulate one sample unless it is the enabled no-data value: saturating add, or running maximum or minimum.
    always_comb begin
        w_skip = r_nodata_en && (r_sample == r_nodata_val);
        w_sext = ACC_W'(r_sample);
        w_sum  = (ACC_W+1)'(r_acc) + (ACC_W+1)'(w_sext);
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sat = w_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[ACC_W-1:0];
        end
        n_acc  = r_acc;
        n_vcnt = r_vcnt;
        if (!w_skip) begin
            n_vcnt = r_vcnt + 1'b1;
            if (!r_have) begin
                n_acc = w_sext;
            end else begin
                case (r_method)
                    METH_MEAN, METH_SUM: n_acc = w_sat;
                    METH_MAX:            n_acc = (w_sext > r_acc) ? w_sext : r_acc;
                    METH_MIN:            n_acc = (w_sext < r_acc) ? w_sext : r_acc;
                    default:             n_acc = r_acc;
                endcase
            end
        end
        n_pos       = r_pos + 1'b1;
        w_close     = (n_pos >= w_size);
        w_div_start = (r_state == ST_ACC) && w_close && (n_vcnt != '0) &&
                      (r_method == METH_MEAN);
    end

    gawn_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_acc),
        .i_divisor  (n_vcnt),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Sequencer, group state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_group_size <= GSIZE_RST;
            r_method     <= METH_MEAN;
            r_nodata_en  <= 1'b0;
            r_nodata_val <= '0;
            r_acc        <= '0;
            r_vcnt       <= '0;
            r_pos        <= '0;
            r_have       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GROUP_SIZE:    r_group_size <= i_cfg_data[GSIZE_W-1:0];
                    CFG_METHOD:        r_method     <= t_method'(i_cfg_data[METHOD_W-1:0]);
                    CFG_NODATA_ENABLE: r_nodata_en  <= i_cfg_data[0];
                    CFG_NODATA_VALUE:  r_nodata_val <= i_cfg_data[SAMPLE_W-1:0];
                    default:           r_nodata_en  <= r_nodata_en;
                endcase
            end

            // A taken result frees the output register unless a new one loads now.
            if (r_out_valid && i_m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (w_close) begin
                        r_acc  <= '0;
                        r_vcnt <= '0;
                        r_pos  <= '0;
                        r_have <= 1'b0;
                        if (n_vcnt == '0) begin
                            r_res       <= EMPTY_CODE;
                            r_res_empty <= 1'b1;
                            r_state     <= ST_OUT;
                        end else if (r_method == METH_MEAN) begin
                            r_res_empty <= 1'b0;
                            r_state     <= ST_DIV;
                        end else begin
                            r_res       <= n_acc;
                            r_res_empty <= 1'b0;
                            r_state     <= ST_OUT;
                        end
                    end else begin
                        r_acc   <= n_acc;
                        r_vcnt  <= n_vcnt;
                        r_pos   <= n_pos;
                        r_have  <= r_have || !w_skip;
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_res   <= w_quot;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Load the result once the previous one has been taken.
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_agg   <= r_res;
                        r_out_empty <= r_res_empty;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture the incoming item.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_axis_tvalid) begin
            r_sample <= i_s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-ACC_W){1'b0}}, r_out_agg};
    assign o_m_axis_tuser  = r_out_empty;

endmodule

`default_nettype wire
